[src/schs_pkg.sv]
// shared widths, register indexes and reset values for the cap height shader
package schs_pkg;

    localparam int DIM_BITS     = 12;
    localparam int SIZE_BITS    = 13;
    localparam int LEN_BITS     = 20;
    localparam int GRAY_BITS    = 8;
    localparam int CFG_IDX_BITS = 3;

    // offset scaling
    localparam int MAG_BITS = DIM_BITS;
    localparam int NUM_BITS = MAG_BITS + LEN_BITS + 2;
    localparam int DEN_BITS = SIZE_BITS + 1;
    localparam int D_BITS   = LEN_BITS + 2;

    // squares and root
    localparam int SQ_BITS    = 2 * D_BITS;
    localparam int D2_BITS    = SQ_BITS + 1;
    localparam int R2_BITS    = 2 * LEN_BITS;
    localparam int RH_BITS    = LEN_BITS + 1;
    localparam int RH2_BITS   = R2_BITS + 1;
    localparam int ROOT_BITS  = RH_BITS;
    localparam int RAD_BITS   = 2 * ROOT_BITS;

    // gray division
    localparam int DIFF_BITS  = ROOT_BITS + 1;
    localparam int GNUM_BITS  = LEN_BITS + 10;
    localparam int GDEN_BITS  = LEN_BITS + 1;
    localparam int GQ_STEPS   = GRAY_BITS;

    // latencies in register stages
    localparam int OFF_LAT  = NUM_BITS + 3;
    localparam int SQRT_LAT = ROOT_BITS;
    localparam int PIPE_LAT = OFF_LAT + 4 + SQRT_LAT + 3 + GQ_STEPS + 1;

    localparam logic [SIZE_BITS-1:0] WIDTH_RST  = SIZE_BITS'(256);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RST = SIZE_BITS'(256);
    localparam logic [LEN_BITS-1:0]  RADIUS_RST = LEN_BITS'(25600);
    localparam logic [LEN_BITS-1:0]  CAP_RST    = LEN_BITS'(2560);
    localparam logic [LEN_BITS-1:0]  SPAN_X_RST = LEN_BITS'(25600);
    localparam logic [LEN_BITS-1:0]  SPAN_Y_RST = LEN_BITS'(25600);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_SPHERE_RAD   = 3'd2,
        CFG_CAP_HEIGHT   = 3'd3,
        CFG_LENS_SPAN_X  = 3'd4,
        CFG_LENS_SPAN_Y  = 3'd5
    } t_cfg_idx;

endpackage

[src/schs_pix_if.sv]
// pixel coordinate channel
interface schs_pix_if import schs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] pixel_col;
    logic [DIM_BITS-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

[src/schs_gray_if.sv]
// gray level channel
interface schs_gray_if import schs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [GRAY_BITS-1:0] gray_level;

    modport source (output valid, output gray_level, input ready);
    modport sink (input valid, input gray_level, output ready);
endinterface

[src/schs_offset.sv]
// centred, scaled, rounded and clamped pixel offset magnitude, pipelined
module schs_offset import schs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DIM_BITS-1:0]  i_pix,
    input  logic [SIZE_BITS-1:0] i_size,
    input  logic [LEN_BITS-1:0]  i_span,
    output logic [D_BITS-1:0]    o_dist
);
    localparam int CMP_BITS = NUM_BITS + DEN_BITS;
    localparam logic [NUM_BITS-1:0] LIM = NUM_BITS'(1) << (D_BITS - 1);

    logic [SIZE_BITS-1:0] sz;
    logic [DIM_BITS-1:0]  half;
    logic [DEN_BITS-1:0]  den;

    logic [MAG_BITS-1:0]  r_mag;
    logic [NUM_BITS-1:0]  r_rem [NUM_BITS+1];
    logic [NUM_BITS-1:0]  r_q   [NUM_BITS+1];
    logic [D_BITS-1:0]    r_dist;

    assign sz   = (i_size == '0) ? SIZE_BITS'(1) : i_size;
    assign half = sz[SIZE_BITS-1:1];
    assign den  = {sz, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= (i_pix >= half) ? (i_pix - half) : (half - i_pix);
            r_rem[0] <= NUM_BITS'({(MAG_BITS + LEN_BITS)'(r_mag * i_span), 1'b0})
                        + NUM_BITS'(sz);
            r_q[0]   <= '0;
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < NUM_BITS; j++) begin : g_div
        localparam int K = NUM_BITS - 1 - j;
        logic [CMP_BITS-1:0] sub;
        logic                take;
        assign sub  = CMP_BITS'(den) << K;
        assign take = CMP_BITS'(r_rem[j]) >= sub;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= take ? (r_rem[j] - sub[NUM_BITS-1:0]) : r_rem[j];
                r_q[j+1]   <= r_q[j] | (take ? (NUM_BITS'(1) << K) : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= (r_q[NUM_BITS] > LIM) ? LIM[D_BITS-1:0] : r_q[NUM_BITS][D_BITS-1:0];
        end
    end

    assign o_dist = r_dist;
endmodule

[src/schs_sqrt.sv]
// pipelined integer square root, one result bit per stage
module schs_sqrt import schs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [RAD_BITS-1:0]  i_rad,
    output logic [ROOT_BITS-1:0] o_root
);
    logic [RAD_BITS-1:0] r_v   [ROOT_BITS];
    logic [RAD_BITS-1:0] r_res [ROOT_BITS];

    for (genvar s = 0; s < ROOT_BITS; s++) begin : g_step
        localparam logic [RAD_BITS-1:0] BIT = RAD_BITS'(1) << (2 * (ROOT_BITS - 1 - s));
        logic [RAD_BITS-1:0] v_in;
        logic [RAD_BITS-1:0] res_in;
        logic [RAD_BITS-1:0] trial;
        if (s == 0) begin : g_first
            assign v_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[s-1];
            assign res_in = r_res[s-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_in >= trial) begin
                    r_v[s]   <= v_in - trial;
                    r_res[s] <= (res_in >> 1) + BIT;
                end else begin
                    r_v[s]   <= v_in;
                    r_res[s] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[ROOT_BITS-1][ROOT_BITS-1:0];
endmodule

[src/spherical_cap_height_shader.sv]
// top level of the spherical lens cap height shader
// takes one pixel word per clock and returns one 8-bit gray word per pixel,
// gray = 255*(1 - ch/h) rounded and saturated, with cap height
// ch = sqrt(max(r^2 - dx^2 - dy^2, (r-h)^2)) - (r-h), lengths in 8 fraction bits;
// fully pipelined: a new pixel may enter every cycle unless the output is stalled;
// the offset divider, square root and gray divider give one bit per stage, and the
// whole pipe holds while a finished word waits at the output. The user must write
// configuration via the plain write port while no pixel is in flight; not enforced.
module spherical_cap_height_shader import schs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [LEN_BITS-1:0]     i_cfg_data,
    schs_pix_if.sink                i_pix,
    schs_gray_if.source             o_gray
);
    // configuration registers
    logic [SIZE_BITS-1:0] r_width, r_height;
    logic [LEN_BITS-1:0]  r_radius, r_cap, r_span_x, r_span_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_radius <= RADIUS_RST;
            r_cap    <= CAP_RST;
            r_span_x <= SPAN_X_RST;
            r_span_y <= SPAN_Y_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[SIZE_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[SIZE_BITS-1:0];
                CFG_SPHERE_RAD:   r_radius <= i_cfg_data;
                CFG_CAP_HEIGHT:   r_cap    <= i_cfg_data;
                CFG_LENS_SPAN_X:  r_span_x <= i_cfg_data;
                CFG_LENS_SPAN_Y:  r_span_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-frame constants, refreshed every cycle from the registers
    logic signed [RH_BITS-1:0] rh;
    logic [R2_BITS-1:0]        r_r2;
    logic [RH2_BITS-1:0]       r_rh2;

    assign rh = $signed({1'b0, r_radius}) - $signed({1'b0, r_cap});

    always_ff @(posedge i_clk) begin
        r_r2  <= R2_BITS'(r_radius * r_radius);
        r_rh2 <= RH2_BITS'(rh * rh);
    end

    // handshake: whole pipe advances unless the output word is stalled
    logic                r_vld [PIPE_LAT];
    logic                en;

    assign en          = !r_vld[PIPE_LAT-1] || o_gray.ready;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_LAT; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_pix.valid;
            for (int i = 1; i < PIPE_LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // scaled offsets from the image centre
    logic [D_BITS-1:0] dx, dy;

    schs_offset u_off_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_pix  (i_pix.pixel_col),
        .i_size (r_width),
        .i_span (r_span_x),
        .o_dist (dx)
    );

    schs_offset u_off_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_pix  (i_pix.pixel_row),
        .i_size (r_height),
        .i_span (r_span_y),
        .o_dist (dy)
    );

    // squared distance and radicand
    logic [SQ_BITS-1:0]  r_dx2, r_dy2;
    logic [D2_BITS-1:0]  r_d2;
    logic [R2_BITS-1:0]  r_inr;
    logic [RAD_BITS-1:0] r_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx2 <= dx * dx;
            r_dy2 <= dy * dy;
            r_d2  <= D2_BITS'(r_dx2) + D2_BITS'(r_dy2);
            // r^2 - d^2, floored at zero
            r_inr <= (D2_BITS'(r_r2) > r_d2) ? (r_r2 - r_d2[R2_BITS-1:0]) : '0;
            // never below (r-h)^2
            r_rad <= (RH2_BITS'(r_inr) < r_rh2) ? RAD_BITS'(r_rh2) : RAD_BITS'(r_inr);
        end
    end

    logic [ROOT_BITS-1:0] root;

    schs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (root)
    );

    // h - ch reduces to r - root
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]        r_diff;
    logic                        r_flat1, r_zero1;
    logic [GNUM_BITS-1:0]        r_gnum;
    logic                        r_flat2, r_zero2;
    logic [GDEN_BITS-1:0]        gden;

    assign diff = $signed({2'b00, r_radius}) - $signed({1'b0, root});
    assign gden = {r_cap, 1'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_diff  <= diff;
            r_flat1 <= (r_cap == '0);
            r_zero1 <= (diff <= 0);
            // 510*diff + h, rounding term for the divide by 2h
            r_gnum  <= GNUM_BITS'(r_diff[LEN_BITS-1:0]) * GNUM_BITS'(510) + GNUM_BITS'(r_cap);
            r_flat2 <= r_flat1;
            r_zero2 <= r_zero1;
        end
    end

    // gray divide: saturation check, then one quotient bit per stage
    logic [GNUM_BITS-1:0] r_grem [GQ_STEPS+1];
    logic [GRAY_BITS-1:0] r_gq   [GQ_STEPS+1];
    logic                 r_sat  [GQ_STEPS+1];
    logic                 r_flat [GQ_STEPS+1];
    logic                 r_zero [GQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_grem[0] <= r_gnum;
            r_gq[0]   <= '0;
            r_sat[0]  <= r_gnum >= (GNUM_BITS'(gden) << GRAY_BITS);
            r_flat[0] <= r_flat2;
            r_zero[0] <= r_zero2;
        end
    end

    for (genvar j = 0; j < GQ_STEPS; j++) begin : g_gdiv
        localparam int K = GQ_STEPS - 1 - j;
        logic [GNUM_BITS-1:0] sub;
        logic                 take;
        assign sub  = GNUM_BITS'(gden) << K;
        assign take = r_grem[j] >= sub;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_grem[j+1] <= take ? (r_grem[j] - sub) : r_grem[j];
                r_gq[j+1]   <= r_gq[j] | (take ? (GRAY_BITS'(1) << K) : '0);
                r_sat[j+1]  <= r_sat[j];
                r_flat[j+1] <= r_flat[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    // output word register
    logic [GRAY_BITS-1:0] r_gray;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_flat[GQ_STEPS]) begin
                r_gray <= '1;
            end else if (r_zero[GQ_STEPS]) begin
                r_gray <= '0;
            end else if (r_sat[GQ_STEPS]) begin
                r_gray <= '1;
            end else begin
                r_gray <= r_gq[GQ_STEPS];
            end
        end
    end

    assign o_gray.valid      = r_vld[PIPE_LAT-1];
    assign o_gray.gray_level = r_gray;
endmodule

[test/tb.sv]
// testbench for the spherical lens cap height shader: directed and random pixels, gray check
module tb;
    import schs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [LEN_BITS-1:0] i_cfg_data;

    schs_pix_if  pix_if ();
    schs_gray_if gray_if ();

    spherical_cap_height_shader DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if.sink),
        .o_gray     (gray_if.source)
    );

    // clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    typedef struct packed {
        logic [DIM_BITS-1:0] col;
        logic [DIM_BITS-1:0] row;
    } t_pixel;

    // shadow copy of the configuration registers
    logic [SIZE_BITS-1:0] shd_width, shd_height;
    logic [LEN_BITS-1:0]  shd_radius, shd_cap, shd_span_x, shd_span_y;

    t_pixel               pending_pixels[$];
    logic [GRAY_BITS-1:0] expected_grays[$];
    int  error_count;
    int  idle_cycles;
    bit  hold_off_req;
    int  hold_off_left;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, bits, rem;
        res = 0;
        rem = v;
        bits = 64'd1 << 62;
        while (bits > rem) bits >>= 2;
        while (bits != 0) begin
            if (rem >= res + bits) begin
                rem -= res + bits;
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    // scaled magnitude of the centred offset in lens units
    function automatic longint unsigned lens_dist(input longint unsigned pix,
            input longint unsigned size, input longint unsigned span);
        longint unsigned sz, half, mag, q;
        sz = (size == 0) ? 1 : size;
        half = sz >> 1;
        mag = (pix >= half) ? pix - half : half - pix;
        q = (mag * span * 2 + sz) / (2 * sz);
        return (q > (64'd1 << (LEN_BITS + 1))) ? (64'd1 << (LEN_BITS + 1)) : q;
    endfunction

    function automatic logic [GRAY_BITS-1:0] shade_pixel(input t_pixel p);
        longint unsigned dx, dy, d2, r2, rh2, inner, gray;
        longint r, h, rh, ch, diff;
        dx = lens_dist(p.col, shd_width, shd_span_x);
        dy = lens_dist(p.row, shd_height, shd_span_y);
        d2 = dx * dx + dy * dy;
        r = shd_radius;
        h = shd_cap;
        rh = r - h;
        r2 = r * r;
        rh2 = rh * rh;
        inner = (r2 > d2) ? r2 - d2 : 0;
        if (inner < rh2) inner = rh2;
        ch = longint'(root_floor(inner)) - rh;
        if (h == 0) begin
            gray = 255;
        end else begin
            diff = h - ch;
            if (diff <= 0) begin
                gray = 0;
            end else begin
                gray = (longint'(diff) * 510 + h) / (2 * h);
                if (gray > 255) gray = 255;
            end
        end
        return gray[GRAY_BITS-1:0];
    endfunction

    // driver: presents queued pixel words with random gaps
    int src_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            pix_if.pixel_col <= '0;
            pix_if.pixel_row <= '0;
            src_gap <= 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                expected_grays.push_back(shade_pixel({pix_if.pixel_col, pix_if.pixel_row}));
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (src_gap > 0 || pending_pixels.size() == 0) begin
                    pix_if.valid <= 1'b0;
                    if (src_gap > 0) src_gap <= src_gap - 1;
                end else begin
                    t_pixel p;
                    p = pending_pixels.pop_front();
                    pix_if.valid <= 1'b1;
                    pix_if.pixel_col <= p.col;
                    pix_if.pixel_row <= p.row;
                    src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                end
            end
        end
    end

    // monitor: checks gray words and stalls the output at random
    int sink_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gray_if.ready <= 1'b0;
            sink_gap <= 0;
            hold_off_left <= 0;
        end else begin
            if (gray_if.valid && gray_if.ready) begin
                if (expected_grays.size() == 0) begin
                    report_mismatch($sformatf("unexpected gray word %0d", gray_if.gray_level));
                end else begin
                    logic [GRAY_BITS-1:0] exp_gray;
                    exp_gray = expected_grays.pop_front();
                    if (exp_gray !== gray_if.gray_level)
                        report_mismatch($sformatf("gray_level got %0d expected %0d",
                            gray_if.gray_level, exp_gray));
                end
            end
            if (hold_off_req && hold_off_left == 0) begin
                // long stall so the pipe fills and backs up the input
                hold_off_left <= 300;
                gray_if.ready <= 1'b0;
            end else if (hold_off_left > 0) begin
                hold_off_left <= hold_off_left - 1;
                gray_if.ready <= (hold_off_left == 1);
            end else if (gray_if.valid && gray_if.ready || !gray_if.ready) begin
                if (sink_gap > 0) begin
                    sink_gap <= sink_gap - 1;
                    gray_if.ready <= 1'b0;
                end else begin
                    gray_if.ready <= 1'b1;
                    sink_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (gray_if.valid && gray_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= LEN_BITS'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  shd_width  = SIZE_BITS'(val);
            CFG_IMAGE_HEIGHT: shd_height = SIZE_BITS'(val);
            CFG_SPHERE_RAD:   shd_radius = LEN_BITS'(val);
            CFG_CAP_HEIGHT:   shd_cap    = LEN_BITS'(val);
            CFG_LENS_SPAN_X:  shd_span_x = LEN_BITS'(val);
            default:          shd_span_y = LEN_BITS'(val);
        endcase
    endtask

    // waits until every queued pixel went in and came back, then lets the pipe drain
    task automatic drain_pipe();
        do
            @(negedge i_clk);
        while (pending_pixels.size() != 0 || pix_if.valid || expected_grays.size() != 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    task automatic queue_pixel(input int col, input int row);
        t_pixel p;
        p.col = DIM_BITS'(col);
        p.row = DIM_BITS'(row);
        pending_pixels.push_back(p);
    endtask

    // random pixels, mostly inside the image, some anywhere in the field
    task automatic queue_random(input int n);
        int w, hgt;
        w = (shd_width == 0) ? 1 : shd_width;
        hgt = (shd_height == 0) ? 1 : shd_height;
        repeat (n) begin
            if ($urandom_range(0, 9) < 8)
                queue_pixel($urandom_range(0, (w > 4096 ? 4096 : w) - 1),
                            $urandom_range(0, (hgt > 4096 ? 4096 : hgt) - 1));
            else
                queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        end
    endtask

    task automatic random_config();
        write_reg(CFG_IMAGE_WIDTH, $urandom_range(0, 8191));
        write_reg(CFG_IMAGE_HEIGHT, $urandom_range(0, 8191));
        write_reg(CFG_SPHERE_RAD, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1048575)
                                                            : $urandom_range(1, 65535));
        write_reg(CFG_CAP_HEIGHT, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1048575)
                                                            : $urandom_range(1, 8191));
        write_reg(CFG_LENS_SPAN_X, $urandom_range(0, 1048575) >> $urandom_range(0, 10));
        write_reg(CFG_LENS_SPAN_Y, $urandom_range(0, 1048575) >> $urandom_range(0, 10));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IMAGE_WIDTH;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel_col = '0;
        pix_if.pixel_row = '0;
        gray_if.ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        hold_off_req = 0;
        shd_width = WIDTH_RST;
        shd_height = HEIGHT_RST;
        shd_radius = RADIUS_RST;
        shd_cap = CAP_RST;
        shd_span_x = SPAN_X_RST;
        shd_span_y = SPAN_Y_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, centre, corners and field extremes
        queue_pixel(128, 128);
        queue_pixel(0, 0);
        queue_pixel(255, 255);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        queue_pixel(2730, 1365);
        queue_pixel(1365, 2730);
        queue_pixel(160, 100);
        drain_pipe();

        // zero image size, zero cap height
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        write_reg(CFG_CAP_HEIGHT, 0);
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(4095, 4095);
        drain_pipe();

        // radius below cap height, maximum width and x span, zero y span
        write_reg(CFG_IMAGE_WIDTH, 8191);
        write_reg(CFG_IMAGE_HEIGHT, 4096);
        write_reg(CFG_SPHERE_RAD, 1);
        write_reg(CFG_CAP_HEIGHT, 1048575);
        write_reg(CFG_LENS_SPAN_X, 1048575);
        write_reg(CFG_LENS_SPAN_Y, 0);
        queue_pixel(0, 0);
        queue_pixel(4095, 2048);
        queue_pixel(2048, 4095);
        drain_pipe();
        write_reg(CFG_SPHERE_RAD, 1048575);
        write_reg(CFG_CAP_HEIGHT, 1);
        write_reg(CFG_IMAGE_WIDTH, 1);
        write_reg(CFG_LENS_SPAN_Y, 1048575);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(2048, 0);
        drain_pipe();

        // back to reset settings with a long output stall while random pixels are queued
        write_reg(CFG_IMAGE_WIDTH, WIDTH_RST);
        write_reg(CFG_IMAGE_HEIGHT, HEIGHT_RST);
        write_reg(CFG_SPHERE_RAD, RADIUS_RST);
        write_reg(CFG_CAP_HEIGHT, CAP_RST);
        write_reg(CFG_LENS_SPAN_X, SPAN_X_RST);
        write_reg(CFG_LENS_SPAN_Y, SPAN_Y_RST);
        queue_random(200);
        hold_off_req = 1;
        wait (hold_off_left > 0);
        hold_off_req = 0;
        drain_pipe();

        // random phases with fresh settings
        repeat (8) begin
            random_config();
            queue_random(140);
            drain_pipe();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[files.f]
src/schs_pkg.sv
src/schs_pix_if.sv
src/schs_gray_if.sv
src/schs_offset.sv
src/schs_sqrt.sv
src/spherical_cap_height_shader.sv
test/tb.sv
